### sv/fptw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fptw_pkg
// Shared types and constants of the four-level page table walker.
// ----------------------------------------------------------------------------
package fptw_pkg;

    localparam int TABLE_PAGES_DEF = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W = 9;

    localparam logic [1:0] REQ_MAP     = 2'd0;
    localparam logic [1:0] REQ_RESOLVE = 2'd1;
    localparam logic [1:0] REQ_ENWR    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_UNMAPPED = 2'd2;

    localparam int B_P  = 0;
    localparam int B_RW = 1;
    localparam int B_US = 2;
    localparam int B_A  = 5;
    localparam int B_PS = 7;
    localparam int B_G  = 8;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_READ,
        S_WAIT,
        S_EVAL,
        S_NEXT,
        S_DONE,
        S_OUT
    } fptw_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       load;       // capture request
        logic       clr_wr;     // write zero at clear address
        logic       alloc;      // write new table entry, advance bump
        logic       follow;     // descend into entry page
        logic       leaf_wr;    // write leaf entry
        logic       set_rw;     // set writable bit of final entry
        logic       next_page;  // advance to next page of a map
        logic       res_load;   // capture resolve result
        logic [1:0] status;
        logic       st_load;
    } fptw_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [1:0] req;
        logic [1:0] level;      // 0: level 4 ... 3: level 1
        logic       entry_zero;
        logic       entry_in_pool;
        logic       entry_large;
        logic       pool_full;
        logic       alloc_in_pool; // new table address does not wrap
        logic       count_zero;
        logic       last_page;
        logic       clear_done;
    } fptw_stat_t;

endpackage
`default_nettype wire

### sv/fptw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fptw_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### sv/fptw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fptw_datapath
// Request registers, table store, bump allocator and result registers.
// ----------------------------------------------------------------------------
module fptw_datapath #(
    parameter int TABLE_PAGES = fptw_pkg::TABLE_PAGES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire fptw_pkg::fptw_cmd_t cmd,
    output fptw_pkg::fptw_stat_t    stat,
    input  wire logic [51:0]        pool_base,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [47:0]        s_virt_addr,
    input  wire logic [51:0]        s_phys_addr,
    input  wire logic [15:0]        s_page_count,
    input  wire logic               s_is_global,
    output logic [1:0]              m_status,
    output logic [51:0]             m_phys_result,
    output logic                    m_leaf_writable,
    output logic                    m_leaf_user
);
    import fptw_pkg::*;

    localparam int PG_W  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int CNT_W = $clog2(TABLE_PAGES + 1);
    localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int AW    = PG_W + IDX_W;

    logic [1:0]       req_reg;
    logic [47:0]      va_reg;
    logic [51:0]      pa_reg;
    logic [15:0]      cnt_reg;
    logic             glob_reg;
    logic [1:0]       lvl_reg;
    logic [PG_W-1:0]  page_reg;
    logic [CNT_W-1:0] free_reg;
    logic [AW-1:0]    clr_reg;
    logic             clr_done_reg;

    logic [IDX_W-1:0] idx;
    logic [AW-1:0]    addr;
    logic             we;
    logic [63:0]      wdata, rdata, entry;
    logic [39:0]      ent_pfn, base_pfn, diff;
    logic [40:0]      new_sum;
    logic [51:0]      new_tab;

    always_comb begin
        unique case (lvl_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    assign entry    = rdata;
    assign ent_pfn  = entry[51:12];
    assign base_pfn = pool_base[51:12];
    assign diff     = ent_pfn - base_pfn;
    // A carry out means the new table address wrapped below the pool.
    assign new_sum  = {1'b0, base_pfn} + 41'(free_reg);
    assign new_tab  = {new_sum[39:0], 12'h000};

    always_comb begin
        addr  = {page_reg, idx};
        we    = 1'b0;
        wdata = entry;
        if (cmd.clr_wr) begin
            addr  = clr_reg;
            we    = 1'b1;
            wdata = '0;
        end else if (cmd.alloc) begin
            we    = 1'b1;
            wdata = {12'h000, new_tab};
            wdata[B_P]  = 1'b1;
            wdata[B_RW] = 1'b1;
            wdata[B_US] = ~glob_reg;
            wdata[B_A]  = (lvl_reg != 2'd2);
        end else if (cmd.leaf_wr) begin
            we    = 1'b1;
            wdata = {12'h000, pa_reg[51:12], 12'h000};
            wdata[B_P]  = 1'b1;
            wdata[B_RW] = 1'b1;
            wdata[B_US] = ~glob_reg;
            wdata[B_G]  = glob_reg;
        end else if (cmd.set_rw) begin
            we    = 1'b1;
            wdata[B_RW] = 1'b1;
        end
    end

    fptw_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg     <= CNT_W'(1);
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
            m_status     <= ST_OK;
        end else begin
            if (cmd.clr_wr) begin
                clr_reg <= clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (cmd.alloc) begin
                free_reg <= free_reg + CNT_W'(1);
            end
            if (cmd.st_load) begin
                m_status <= cmd.status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_req_type;
            va_reg   <= s_virt_addr;
            pa_reg   <= s_phys_addr;
            cnt_reg  <= s_page_count;
            glob_reg <= s_is_global;
            lvl_reg  <= 2'd0;
            page_reg <= '0;
            m_phys_result   <= '0;
            m_leaf_writable <= 1'b0;
            m_leaf_user     <= 1'b0;
        end else begin
            if (cmd.alloc) begin
                page_reg <= free_reg[PG_W-1:0];
                lvl_reg  <= lvl_reg + 2'd1;
            end
            if (cmd.follow) begin
                page_reg <= diff[PG_W-1:0];
                lvl_reg  <= lvl_reg + 2'd1;
            end
            if (cmd.next_page) begin
                va_reg   <= va_reg + 48'h1000;
                pa_reg   <= pa_reg + 52'h1000;
                cnt_reg  <= cnt_reg - 16'd1;
                lvl_reg  <= 2'd0;
                page_reg <= '0;
            end
            if (cmd.res_load) begin
                if (lvl_reg == 2'd2) begin
                    m_phys_result <= {entry[51:21], va_reg[20:0]};
                end else begin
                    m_phys_result <= {entry[51:12], va_reg[11:0]};
                end
                m_leaf_writable <= entry[B_RW];
                m_leaf_user     <= entry[B_US];
            end
        end
    end

    always_comb begin
        stat.req           = req_reg;
        stat.level         = lvl_reg;
        stat.entry_zero    = (entry == '0);
        stat.entry_in_pool = (ent_pfn >= base_pfn) && (diff < 40'(TABLE_PAGES));
        stat.entry_large   = entry[B_PS];
        stat.pool_full     = (free_reg >= CNT_W'(TABLE_PAGES));
        stat.alloc_in_pool = ~new_sum[40];
        stat.count_zero    = (cnt_reg == 16'd0);
        stat.last_page     = (cnt_reg == 16'd1);
        stat.clear_done    = clr_done_reg;
    end
endmodule
`default_nettype wire

### sv/fptw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fptw_ctrl
// Walk sequencer: clearing pass, level walk, allocation and handshakes.
// ----------------------------------------------------------------------------
module fptw_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire fptw_pkg::fptw_stat_t stat,
    output fptw_pkg::fptw_cmd_t      cmd
);
    import fptw_pkg::*;

    fptw_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                if (stat.clear_done) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.clr_wr = 1'b1;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (stat.req == REQ_MAP && stat.count_zero) begin
                    cmd.st_load = 1'b1;
                    cmd.status  = ST_OK;
                    state_next  = S_OUT;
                end else if (stat.req == REQ_MAP || stat.req == REQ_RESOLVE
                             || stat.req == REQ_ENWR) begin
                    state_next = S_READ;
                end else begin
                    cmd.st_load = 1'b1;
                    cmd.status  = ST_OK;
                    state_next  = S_OUT;
                end
            end
            S_READ: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.st_load = 1'b1;
                cmd.status  = ST_OK;
                if (stat.req == REQ_MAP) begin
                    if (stat.level == 2'd3) begin
                        cmd.leaf_wr = 1'b1;
                        state_next  = S_NEXT;
                    end else if (stat.entry_zero) begin
                        if (stat.pool_full) begin
                            cmd.status = ST_FULL;
                            state_next = S_OUT;
                        end else begin
                            cmd.alloc = 1'b1;
                            if (stat.alloc_in_pool) begin
                                state_next = S_READ;
                            end else begin
                                cmd.status = ST_UNMAPPED;
                                state_next = S_OUT;
                            end
                        end
                    end else if (stat.entry_in_pool) begin
                        cmd.follow = 1'b1;
                        state_next = S_READ;
                    end else begin
                        cmd.status = ST_UNMAPPED;
                        state_next = S_OUT;
                    end
                end else begin
                    if (stat.entry_zero) begin
                        cmd.status = ST_UNMAPPED;
                        state_next = S_OUT;
                    end else if (stat.level == 2'd3
                                 || (stat.level == 2'd2 && stat.entry_large)) begin
                        if (stat.req == REQ_RESOLVE) begin
                            cmd.res_load = 1'b1;
                        end else begin
                            cmd.set_rw = 1'b1;
                        end
                        state_next = S_OUT;
                    end else if (stat.entry_in_pool) begin
                        cmd.follow = 1'b1;
                        state_next = S_READ;
                    end else begin
                        cmd.status = ST_UNMAPPED;
                        state_next = S_OUT;
                    end
                end
            end
            S_NEXT: begin
                if (stat.last_page) begin
                    state_next = S_OUT;
                end else begin
                    cmd.next_page = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_DONE: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### sv/four_level_page_table_map_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_map_walk
// Four-level page table keeper with map, resolve and enable-write requests.
// ----------------------------------------------------------------------------
// The block holds TABLE_PAGES table pages of 512 entries in one single-port
// RAM, with page 0 as the root. After reset it runs a clearing pass that
// writes zero to every entry before it takes the first item. Each table level
// steps through the read, RAM wait and evaluate states; a missing table is
// allocated by a write in the evaluate state of its level. A resolve or
// enable-write walk stops early at a large page on level 2 or at an empty
// entry; a map item walks each of its pages in turn. One item is in flight
// at a time, and the result is held on the m_ channel until taken. pool_base
// is to be written only while the block is idle; the block itself does not
// enforce it.
// ----------------------------------------------------------------------------
module four_level_page_table_map_walk #(
    parameter int TABLE_PAGES = fptw_pkg::TABLE_PAGES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [51:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [47:0] s_virt_addr,
    input  wire logic [51:0] s_phys_addr,
    input  wire logic [15:0] s_page_count,
    input  wire logic        s_is_global,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [51:0]      m_phys_result,
    output logic             m_leaf_writable,
    output logic             m_leaf_user
);
    import fptw_pkg::*;

    fptw_cmd_t   cmd;
    fptw_stat_t  stat;
    logic [51:0] pool_base_reg;

    // The low 12 bits are dropped so the pool stays page aligned.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= '0;
        end else if (cfg_valid) begin
            pool_base_reg <= {cfg_data[51:12], 12'h000};
        end
    end

    fptw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fptw_datapath #(.TABLE_PAGES(TABLE_PAGES)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .pool_base       (pool_base_reg),
        .s_req_type      (s_req_type),
        .s_virt_addr     (s_virt_addr),
        .s_phys_addr     (s_phys_addr),
        .s_page_count    (s_page_count),
        .s_is_global     (s_is_global),
        .m_status        (m_status),
        .m_phys_result   (m_phys_result),
        .m_leaf_writable (m_leaf_writable),
        .m_leaf_user     (m_leaf_user)
    );
endmodule
`default_nettype wire
